### rtl/irpd_pkg.sv
// shared types, widths and register codes for the infrared pulse-distance frame encoder
// no dependencies; every other file refers to it by scoped names
package irpd_pkg;

   // frame and field sizes
   localparam int MAX_FRAME_BYTES = 16;
   localparam int BYTE_W          = 8;
   localparam int DUR_W           = 16;
   localparam int FLEN_W          = 5;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int QUEUE_DEPTH     = 2;

   // derived widths
   localparam int POS_W     = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_BASE  = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W     = (LEN_BASE > FLEN_W) ? LEN_BASE : FLEN_W;
   localparam int STEP_W    = $clog2(2 * BYTE_W);
   localparam int BIT_IDX_W = $clog2(BYTE_W);
   localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   // last mark/space step of the data bits
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * BYTE_W - 1);

   // reset values of the timing registers
   localparam logic [DUR_W-1:0]  RST_HEADER_MARK  = 16'd7810;
   localparam logic [DUR_W-1:0]  RST_HEADER_SPACE = 16'd2868;
   localparam logic [DUR_W-1:0]  RST_BIT_MARK     = 16'd552;
   localparam logic [DUR_W-1:0]  RST_ZERO_SPACE   = 16'd1447;
   localparam logic [DUR_W-1:0]  RST_ONE_SPACE    = 16'd2868;
   localparam logic [DUR_W-1:0]  RST_FOOTER_SPACE = 16'd10126;
   localparam logic [FLEN_W-1:0] RST_FRAME_LENGTH = 5'd9;

   // register indexes of the write port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADER_MARK  = 3'd0,
      REG_HEADER_SPACE = 3'd1,
      REG_BIT_MARK     = 3'd2,
      REG_ZERO_SPACE   = 3'd3,
      REG_ONE_SPACE    = 3'd4,
      REG_FOOTER_SPACE = 3'd5,
      REG_FRAME_LENGTH = 3'd6
   } reg_index_type;

   // timing and framing settings as seen by the datapath
   typedef struct packed {
      logic [DUR_W-1:0]  header_mark;
      logic [DUR_W-1:0]  header_space;
      logic [DUR_W-1:0]  mark_burst;
      logic [DUR_W-1:0]  gap_zero;
      logic [DUR_W-1:0]  gap_one;
      logic [DUR_W-1:0]  gap_trailer;
      logic [FLEN_W-1:0] frame_length;
   } timing_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first;
      logic              last;
   } entry_type;

endpackage

### rtl/ir_pulse_distance_frame_encoder_top.sv
// Infrared pulse-distance frame encoder. Each frame byte pushed in produces a run of
// mark/space durations, one result per clock cycle while the result side keeps popping:
// 16 results per byte, 18 on the first or last byte of a frame, 20 when the frame is a
// single byte. The back-end sequencer emits one duration per cycle into the result
// register whenever that register is empty or being popped. A two-entry queue sits
// between the byte classifier and the sequencer, so new bytes are taken while earlier
// ones are still being sent, and a run follows the previous one with no gap when its
// byte is already queued. Frame length 0 is treated as 1 and lengths above 16 saturate
// at 16. Settings may only be written while no results are outstanding.
// depends on irpd_pkg, irpd_csr, irpd_front, irpd_queue and irpd_back
module ir_pulse_distance_frame_encoder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [irpd_pkg::BYTE_W-1:0]      req_data_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_level,
   output logic [irpd_pkg::DUR_W-1:0]       rsp_duration_us,
   output logic                             rsp_end_of_frame,
   output logic                             rsp_last_of_run,
   input  logic                             csr_write,
   input  logic [irpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [irpd_pkg::CSR_DATA_W-1:0]  csr_data
);

   irpd_pkg::timing_type timing;
   irpd_pkg::entry_type  push_entry;
   irpd_pkg::entry_type  q_head;
   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_valid;

   // settings
   irpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .timing    (timing)
   );

   // byte intake and classification
   irpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .frame_length  (timing.frame_length),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // decoupling queue
   irpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   // duration sequencer
   irpd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .timing           (timing),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_level        (rsp_level),
      .rsp_duration_us  (rsp_duration_us),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

### rtl/irpd_csr.sv
// configuration registers of the infrared pulse-distance frame encoder
// depends on irpd_pkg for register codes, widths and reset values
module irpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [irpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [irpd_pkg::CSR_DATA_W-1:0]  csr_data,
   output irpd_pkg::timing_type             timing
);

   irpd_pkg::timing_type regs_ff;
   irpd_pkg::timing_type regs_in;

   // register write decoder; unknown indexes are dropped
   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         unique case (csr_index)
            irpd_pkg::REG_HEADER_MARK:  regs_in.header_mark  = csr_data;
            irpd_pkg::REG_HEADER_SPACE: regs_in.header_space = csr_data;
            irpd_pkg::REG_BIT_MARK:     regs_in.mark_burst   = csr_data;
            irpd_pkg::REG_ZERO_SPACE:   regs_in.gap_zero     = csr_data;
            irpd_pkg::REG_ONE_SPACE:    regs_in.gap_one      = csr_data;
            irpd_pkg::REG_FOOTER_SPACE: regs_in.gap_trailer  = csr_data;
            irpd_pkg::REG_FRAME_LENGTH:
               regs_in.frame_length = csr_data[irpd_pkg::FLEN_W-1:0];
            default: regs_in = regs_ff;
         endcase
      end
   end

   // settings storage
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.header_mark  <= irpd_pkg::RST_HEADER_MARK;
         regs_ff.header_space <= irpd_pkg::RST_HEADER_SPACE;
         regs_ff.mark_burst   <= irpd_pkg::RST_BIT_MARK;
         regs_ff.gap_zero     <= irpd_pkg::RST_ZERO_SPACE;
         regs_ff.gap_one      <= irpd_pkg::RST_ONE_SPACE;
         regs_ff.gap_trailer  <= irpd_pkg::RST_FOOTER_SPACE;
         regs_ff.frame_length <= irpd_pkg::RST_FRAME_LENGTH;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign timing = regs_ff;

endmodule

### rtl/irpd_front.sv
// front end: accepts frame bytes, tracks the byte position and marks first/last bytes
// depends on irpd_pkg for widths and the queue entry type
module irpd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [irpd_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [irpd_pkg::FLEN_W-1:0]   frame_length,
   input  logic                          q_full,
   output logic                          q_push,
   output irpd_pkg::entry_type           q_entry
);

   logic [irpd_pkg::POS_W-1:0] pos_ff;
   logic [irpd_pkg::POS_W-1:0] pos_in;
   logic [irpd_pkg::LEN_W-1:0] len_raw;
   logic [irpd_pkg::LEN_W-1:0] len_eff;
   logic [irpd_pkg::LEN_W-1:0] pos_next;
   logic                       last;

   // effective frame length: zero counts as one, saturate at the maximum
   always_comb begin
      len_raw = irpd_pkg::LEN_W'(frame_length);
      if (frame_length == '0) begin
         len_eff = irpd_pkg::LEN_W'(1);
      end else if (len_raw > irpd_pkg::LEN_W'(irpd_pkg::MAX_FRAME_BYTES)) begin
         len_eff = irpd_pkg::LEN_W'(irpd_pkg::MAX_FRAME_BYTES);
      end else begin
         len_eff = len_raw;
      end
   end

   // classify the incoming item
   assign pos_next = irpd_pkg::LEN_W'(pos_ff) + irpd_pkg::LEN_W'(1);
   assign last     = (pos_next >= len_eff);

   assign req_full          = q_full;
   assign q_push            = req_push && !q_full;
   assign q_entry.data_byte = req_data_byte;
   assign q_entry.first     = (pos_ff == '0);
   assign q_entry.last      = last;

   // byte position counter
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         pos_in = last ? '0 : pos_next[irpd_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### rtl/irpd_queue.sv
// short queue of classified bytes between the front end and the sequencer
// depends on irpd_pkg for the entry type and queue depth
module irpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  irpd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output irpd_pkg::entry_type head
);

   irpd_pkg::entry_type              slot_ff [irpd_pkg::QUEUE_DEPTH];
   logic [irpd_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [irpd_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [irpd_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [irpd_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [irpd_pkg::QCNT_W-1:0]      count_ff;
   logic [irpd_pkg::QCNT_W-1:0]      count_in;

   localparam logic [irpd_pkg::QPTR_W-1:0] PTR_END =
      irpd_pkg::QPTR_W'(irpd_pkg::QUEUE_DEPTH - 1);
   localparam logic [irpd_pkg::QCNT_W-1:0] CNT_FULL =
      irpd_pkg::QCNT_W'(irpd_pkg::QUEUE_DEPTH);

   assign full  = (count_ff == CNT_FULL);
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_END) ? '0 : wr_ptr_ff + irpd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_END) ? '0 : rd_ptr_ff + irpd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + irpd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - irpd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !valid |-> !pop)
      else $error("queue read while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill count beyond its depth");
`endif

endmodule

### rtl/irpd_back.sv
// back end: sequences header, bit and footer durations for one byte at a time
// depends on irpd_pkg for the entry and timing types
module irpd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  irpd_pkg::timing_type          timing,
   input  logic                          q_valid,
   input  irpd_pkg::entry_type           q_head,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_level,
   output logic [irpd_pkg::DUR_W-1:0]    rsp_duration_us,
   output logic                          rsp_end_of_frame,
   output logic                          rsp_last_of_run
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HEADER,
      ST_BITS,
      ST_FOOTER
   } state_type;

   state_type                      state_ff, state_in;
   logic [irpd_pkg::STEP_W-1:0]    step_ff, step_in;
   irpd_pkg::entry_type            cur_ff, cur_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           level_ff, level_in;
   logic [irpd_pkg::DUR_W-1:0]     dur_ff, dur_in;
   logic                           eof_ff, eof_in;
   logic                           lor_ff, lor_in;

   logic                           advance;
   logic                           res_level;
   logic [irpd_pkg::DUR_W-1:0]     res_dur;
   logic                           res_eof;
   logic                           res_done;
   state_type                      res_state;
   logic [irpd_pkg::STEP_W-1:0]    res_step;
   logic [irpd_pkg::BIT_IDX_W-1:0] bit_idx;
   logic                           space;

   assign advance = !out_valid_ff || rsp_pop;
   assign bit_idx = step_ff[irpd_pkg::STEP_W-1:1];
   assign space   = step_ff[0];

   // duration of the current step and where the sequence goes next
   always_comb begin
      res_level = !space;
      res_dur   = timing.mark_burst;
      res_eof   = 1'b0;
      res_done  = 1'b0;
      res_state = state_ff;
      res_step  = step_ff + irpd_pkg::STEP_W'(1);
      unique case (state_ff)
         ST_HEADER: begin
            res_dur = space ? timing.header_space : timing.header_mark;
            if (space) begin
               res_state = ST_BITS;
               res_step  = '0;
            end
         end
         ST_BITS: begin
            if (space) begin
               res_dur = cur_ff.data_byte[bit_idx] ? timing.gap_one : timing.gap_zero;
            end
            if (step_ff == irpd_pkg::STEP_LAST) begin
               res_done  = !cur_ff.last;
               res_state = ST_FOOTER;
               res_step  = '0;
            end
         end
         ST_FOOTER: begin
            res_dur  = space ? timing.gap_trailer : timing.mark_burst;
            res_eof  = space;
            res_done = space;
         end
         default: begin
            res_level = 1'b0;
         end
      endcase
   end

   // sequencer control and result register
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff;
      level_in     = level_ff;
      dur_in       = dur_ff;
      eof_in       = eof_ff;
      lor_in       = lor_ff;
      q_pop        = 1'b0;
      if (advance) begin
         out_valid_in = 1'b0;
      end
      if (state_ff == ST_IDLE) begin
         if (q_valid) begin
            q_pop    = 1'b1;
            cur_in   = q_head;
            step_in  = '0;
            state_in = q_head.first ? ST_HEADER : ST_BITS;
         end
      end else if (advance) begin
         out_valid_in = 1'b1;
         level_in     = res_level;
         dur_in       = res_dur;
         eof_in       = res_eof;
         lor_in       = res_done;
         if (res_done) begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               step_in  = '0;
               state_in = q_head.first ? ST_HEADER : ST_BITS;
            end else begin
               state_in = ST_IDLE;
            end
         end else begin
            state_in = res_state;
            step_in  = res_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff  <= step_in;
      cur_ff   <= cur_in;
      level_ff <= level_in;
      dur_ff   <= dur_in;
      eof_ff   <= eof_in;
      lor_ff   <= lor_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_level        = level_ff;
   assign rsp_duration_us  = dur_ff;
   assign rsp_end_of_frame = eof_ff;
   assign rsp_last_of_run  = lor_ff;

`ifndef ASSERT_OFF
   a_eof_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && eof_ff) |-> (lor_ff && !level_ff))
      else $error("footer space not flagged as last of run");

   a_footer_only_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOOTER) |-> cur_ff.last)
      else $error("footer sequenced for a byte that is not last in frame");

   a_pop_at_boundary: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> ((state_ff == ST_IDLE) || (advance && res_done)))
      else $error("new byte taken while one is still being sequenced");
`endif

endmodule
